// ===== design/sdps_pkg.sv =====
// Shared types, codes and reset values for the steer/drive pulse sequencer.
package sdps_pkg;

    localparam int TickW  = 16;
    localparam int PaddrW = 4;
    localparam int PdataW = 32;

    typedef logic [TickW-1:0] t_ticks;

    typedef struct packed {
        t_ticks minor_turn;
        t_ticks large_turn;
        t_ticks reverse_pause;
        t_ticks run_pulse;
    } t_cfg;

    localparam t_ticks SMALL_TURN_RST    = 16'd100;
    localparam t_ticks LARGE_TURN_RST    = 16'd200;
    localparam t_ticks REVERSE_PAUSE_RST = 16'd500;
    localparam t_ticks RUN_PULSE_RST     = 16'd200;

    localparam logic [1:0] REG_SMALL_TURN    = 2'd0;
    localparam logic [1:0] REG_LARGE_TURN    = 2'd1;
    localparam logic [1:0] REG_REVERSE_PAUSE = 2'd2;
    localparam logic [1:0] REG_RUN_PULSE     = 2'd3;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_STEER = 3'd1;
    localparam logic [2:0] CMD_FWD   = 3'd2;
    localparam logic [2:0] CMD_BACK  = 3'd3;
    localparam logic [2:0] CMD_DRIVE = 3'd4;
    localparam logic [2:0] CMD_RUN   = 3'd5;

    localparam logic [2:0] PEND_NONE  = 3'd0;
    localparam logic [2:0] PEND_STEER = 3'd1;
    localparam logic [2:0] PEND_FWD   = 3'd2;
    localparam logic [2:0] PEND_BACK  = 3'd3;
    localparam logic [2:0] PEND_RUN   = 3'd4;

    localparam logic [1:0] MODE_NEUTRAL = 2'd0;
    localparam logic [1:0] MODE_FWD     = 2'd1;
    localparam logic [1:0] MODE_BACK    = 2'd2;

    localparam logic [2:0] STEER_STRAIGHT = 3'b000;
    localparam logic [2:0] STEER_SMALL_R  = 3'b001;
    localparam logic [2:0] STEER_LARGE_R  = 3'b010;
    localparam logic [2:0] STEER_SMALL_L  = 3'b111;
    localparam logic [2:0] STEER_LARGE_L  = 3'b110;

    localparam int PIN_FWD   = 0;
    localparam int PIN_BACK  = 1;
    localparam int PIN_LEFT  = 2;
    localparam int PIN_RIGHT = 3;
    localparam int PIN_RUN   = 4;

    typedef struct packed {
        logic fwd_pin;
        logic back_pin;
        logic left_pin;
        logic right_pin;
        logic run_pulse_pin;
        logic busy_res;
        logic running;
        logic rejected;
    } t_res;

endpackage

// ===== design/sdps_if.sv =====
// Request and result channel interfaces of the steer/drive pulse sequencer.
interface sdps_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        command;
    logic signed [2:0] steer_amount;
    logic              drive_level;

    modport source(output valid, command, steer_amount, drive_level, input ready);
    modport sink(input valid, command, steer_amount, drive_level, output ready);
endinterface

interface sdps_out_if;
    logic valid;
    logic ready;
    logic fwd_pin;
    logic back_pin;
    logic left_pin;
    logic right_pin;
    logic run_pulse_pin;
    logic busy_res;
    logic running;
    logic rejected;

    modport source(output valid, fwd_pin, back_pin, left_pin, right_pin, run_pulse_pin,
                   busy_res, running, rejected, input ready);
    modport sink(input valid, fwd_pin, back_pin, left_pin, right_pin, run_pulse_pin,
                 busy_res, running, rejected, output ready);
endinterface

// ===== design/sdps_cfg.sv =====
// APB register bank holding the tick lengths of the timed phases.
module sdps_cfg import sdps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [PaddrW-1:0] paddr,
    input  logic [PdataW-1:0] pwdata,
    output logic [PdataW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;
    t_ticks     rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[PaddrW-1:2];
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_SMALL_TURN:    n_cfg.minor_turn    = pwdata[TickW-1:0];
                REG_LARGE_TURN:    n_cfg.large_turn    = pwdata[TickW-1:0];
                REG_REVERSE_PAUSE: n_cfg.reverse_pause = pwdata[TickW-1:0];
                REG_RUN_PULSE:     n_cfg.run_pulse     = pwdata[TickW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SMALL_TURN:    rd_val = r_cfg.minor_turn;
            REG_LARGE_TURN:    rd_val = r_cfg.large_turn;
            REG_REVERSE_PAUSE: rd_val = r_cfg.reverse_pause;
            REG_RUN_PULSE:     rd_val = r_cfg.run_pulse;
            default:           rd_val = '0;
        endcase
    end

    assign prdata = {{(PdataW-TickW){1'b0}}, rd_val};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.minor_turn    <= SMALL_TURN_RST;
            r_cfg.large_turn    <= LARGE_TURN_RST;
            r_cfg.reverse_pause <= REVERSE_PAUSE_RST;
            r_cfg.run_pulse     <= RUN_PULSE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== design/steer_drive_pulse_sequencer.sv =====
// Steer/drive pulse sequencer top level: request step logic and result buffering.
// Each accepted request's result is registered into the output register, or into the skid entry if it stays full.
// Throughput: one request per cycle while the skid entry is free; the state step is a single registered update.
// A two-entry result buffer (output register plus skid) keeps requests flowing
// while a result waits; ready drops only when both entries are full.
// Reset: synchronous active low; pins low, neutral, running, idle, tick lengths 100/200/500/200.
module steer_drive_pulse_sequencer import sdps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sdps_in_if.sink           i_req,
    sdps_out_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [PaddrW-1:0] paddr,
    input  logic [PdataW-1:0] pwdata,
    output logic [PdataW-1:0] prdata,
    output logic              pready
);

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] last;
        logic       run;
        t_ticks     timer;
        logic [2:0] pend;
        logic [4:0] pins;
    } t_state;

    t_cfg   cfg;
    t_state r_st;
    t_state n_st;
    t_res   step_res;
    t_res   r_out;
    t_res   n_out;
    t_res   r_skid;
    t_res   n_skid;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   r_skid_valid;
    logic   n_skid_valid;
    logic   accept;
    logic   take;

    sdps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    function automatic t_ticks phase_len(t_ticks len);
        return (len == '0) ? t_ticks'(1) : len;
    endfunction

    function automatic t_state finish_phase(t_state st);
        t_state nx;
        nx = st;
        case (st.pend)
            PEND_STEER: begin
                nx.pins[PIN_LEFT]  = 1'b0;
                nx.pins[PIN_RIGHT] = 1'b0;
            end
            PEND_FWD: begin
                nx.pins[PIN_FWD]  = 1'b1;
                nx.pins[PIN_BACK] = 1'b0;
                nx.mode           = MODE_FWD;
            end
            PEND_BACK: begin
                nx.pins[PIN_BACK] = 1'b1;
                nx.pins[PIN_FWD]  = 1'b0;
                nx.mode           = MODE_BACK;
            end
            PEND_RUN: begin
                nx.pins[PIN_RUN]   = 1'b0;
                nx.pins[PIN_LEFT]  = 1'b0;
                nx.pins[PIN_RIGHT] = 1'b0;
                nx.run             = ~st.run;
            end
            default: ;
        endcase
        nx.pend = PEND_NONE;
        return nx;
    endfunction

    assign i_req.ready = ~r_skid_valid;
    assign accept      = i_req.valid & ~r_skid_valid;
    assign take        = r_out_valid & o_res.ready;

    // request step
    always_comb begin
        logic       busy;
        logic       rej;
        logic       go;
        logic       right;
        logic       long_pulse;
        logic [2:0] s;
        n_st       = r_st;
        busy       = (r_st.timer != '0);
        rej        = 1'b0;
        go         = 1'b0;
        right      = 1'b0;
        long_pulse = 1'b0;
        s          = i_req.steer_amount;
        if ((i_req.command inside {[CMD_STEER:CMD_RUN]}) && busy) begin
            rej = 1'b1;
        end else begin
            case (i_req.command)
                CMD_TICK: begin
                    if (busy) begin
                        n_st.timer = r_st.timer - t_ticks'(1);
                        if (n_st.timer == '0) begin
                            n_st = finish_phase(n_st);
                        end
                    end
                end
                CMD_STEER: begin
                    if (s == STEER_SMALL_R || s == STEER_LARGE_R) begin
                        go         = 1'b1;
                        right      = 1'b1;
                        long_pulse = (s == STEER_LARGE_R);
                        n_st.last  = s;
                    end else if (s == STEER_SMALL_L || s == STEER_LARGE_L) begin
                        go         = 1'b1;
                        long_pulse = (s == STEER_LARGE_L);
                        n_st.last  = s;
                    end else if (s == STEER_STRAIGHT) begin
                        if (!r_st.last[2] && r_st.last != STEER_STRAIGHT) begin
                            go         = 1'b1;
                            long_pulse = (r_st.last == STEER_LARGE_R);
                            n_st.last  = STEER_STRAIGHT;
                        end else if (r_st.last[2]) begin
                            go         = 1'b1;
                            right      = 1'b1;
                            long_pulse = (r_st.last == STEER_LARGE_L);
                            n_st.last  = STEER_STRAIGHT;
                        end
                    end
                    if (go) begin
                        n_st.pins[PIN_LEFT]  = ~right;
                        n_st.pins[PIN_RIGHT] = right;
                        n_st.timer = phase_len(long_pulse ? cfg.large_turn : cfg.minor_turn);
                        n_st.pend  = PEND_STEER;
                    end
                end
                CMD_FWD: begin
                    if (r_st.mode == MODE_BACK) begin
                        n_st.pins[PIN_FWD]  = 1'b0;
                        n_st.pins[PIN_BACK] = 1'b0;
                        n_st.timer          = phase_len(cfg.reverse_pause);
                        n_st.pend           = PEND_FWD;
                    end else begin
                        n_st.pend = PEND_FWD;
                        n_st      = finish_phase(n_st);
                    end
                end
                CMD_BACK: begin
                    if (r_st.mode == MODE_FWD) begin
                        n_st.pins[PIN_FWD]  = 1'b0;
                        n_st.pins[PIN_BACK] = 1'b0;
                        n_st.timer          = phase_len(cfg.reverse_pause);
                        n_st.pend           = PEND_BACK;
                    end else begin
                        n_st.pend = PEND_BACK;
                        n_st      = finish_phase(n_st);
                    end
                end
                CMD_DRIVE: begin
                    n_st.pins[PIN_FWD] = i_req.drive_level;
                    n_st.mode          = i_req.drive_level ? MODE_FWD : MODE_NEUTRAL;
                end
                CMD_RUN: begin
                    n_st.pins[PIN_RUN] = 1'b1;
                    n_st.timer         = phase_len(cfg.run_pulse);
                    n_st.pend          = PEND_RUN;
                end
                default: ;
            endcase
        end
        step_res.fwd_pin       = n_st.pins[PIN_FWD];
        step_res.back_pin      = n_st.pins[PIN_BACK];
        step_res.left_pin      = n_st.pins[PIN_LEFT];
        step_res.right_pin     = n_st.pins[PIN_RIGHT];
        step_res.run_pulse_pin = n_st.pins[PIN_RUN];
        step_res.busy_res      = (n_st.timer != '0);
        step_res.running       = n_st.run;
        step_res.rejected      = rej;
    end

    // result buffer
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (accept) begin
            if (!n_out_valid) begin
                n_out       = step_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = step_res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.mode    <= MODE_NEUTRAL;
            r_st.last    <= STEER_STRAIGHT;
            r_st.run     <= 1'b1;
            r_st.timer   <= '0;
            r_st.pend    <= PEND_NONE;
            r_st.pins    <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_st <= n_st;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.fwd_pin       = r_out.fwd_pin;
    assign o_res.back_pin      = r_out.back_pin;
    assign o_res.left_pin      = r_out.left_pin;
    assign o_res.right_pin     = r_out.right_pin;
    assign o_res.run_pulse_pin = r_out.run_pulse_pin;
    assign o_res.busy_res      = r_out.busy_res;
    assign o_res.running       = r_out.running;
    assign o_res.rejected      = r_out.rejected;

endmodule
